[hw/rtl/itoa_pkg.sv]
`default_nettype none
package itoa_pkg;

  localparam int unsigned VALUE_W     = 32;
  localparam int unsigned CHAR_W      = 6;
  localparam int unsigned DIGIT_W     = 4;
  localparam int unsigned MAX_DIGITS  = 10;
  localparam int unsigned DIGIT_IDX_W = $clog2(MAX_DIGITS);
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [CHAR_W-1:0] CHAR_MINUS = 6'd45;
  localparam logic [CHAR_W-1:0] CHAR_ZERO  = 6'd48;

  // floor(x / 10) == (x * RECIP_TEN) >> RECIP_SHIFT for every 32-bit x
  localparam logic [VALUE_W-1:0] RECIP_TEN   = 32'hCCCC_CCCD;
  localparam int unsigned        RECIP_SHIFT = 35;
  localparam int unsigned        QUOT_W      = 2 * VALUE_W - RECIP_SHIFT;

  typedef struct packed {
    logic               negative;
    logic [VALUE_W-1:0] mag;
  } job_t;

endpackage
`default_nettype wire

[hw/rtl/itoa_in_if.sv]
`default_nettype none
interface itoa_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] value;

  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface
`default_nettype wire

[hw/rtl/itoa_out_if.sv]
`default_nettype none
interface itoa_out_if;
  logic       valid;
  logic       ready;
  logic [5:0] char_code;
  logic       last_char;

  modport source (output valid, output char_code, output last_char, input ready);
  modport sink   (input valid, input char_code, input last_char, output ready);
endinterface
`default_nettype wire

[hw/rtl/signed_int_to_decimal_ascii_top.sv]
// The digit engine does one divide-by-ten step per digit, then sends one character per
// cycle while the output is not stalled; it takes a new number only when idle again.
// A two-word queue between the input stage and the digit engine lets both stall apart.
// Reset (rst, synchronous, active high) empties the input register, queue and output
// register and returns the engine to idle; no other state is kept.
`default_nettype none
module signed_int_to_decimal_ascii_top (
  input  wire logic clk,
  input  wire logic rst,
  itoa_in_if.sink   in_ch,
  itoa_out_if.source out_ch
);
  import itoa_pkg::*;

  logic push_valid;
  job_t push_job;
  logic push_ready;
  logic pop_valid;
  job_t pop_job;
  logic pop_ready;

  itoa_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_ch     (in_ch),
    .job_valid (push_valid),
    .job       (push_job),
    .job_ready (push_ready)
  );

  itoa_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_job   (push_job),
    .push_ready (push_ready),
    .pop_valid  (pop_valid),
    .pop_job    (pop_job),
    .pop_ready  (pop_ready)
  );

  itoa_back u_back (
    .clk       (clk),
    .rst       (rst),
    .job_valid (pop_valid),
    .job       (pop_job),
    .job_ready (pop_ready),
    .out_ch    (out_ch)
  );

endmodule
`default_nettype wire

[hw/rtl/itoa_front.sv]
`default_nettype none
module itoa_front (
  input  wire logic        clk,
  input  wire logic        rst,
  itoa_in_if.sink          in_ch,
  output logic             job_valid,
  output itoa_pkg::job_t   job,
  input  wire logic        job_ready
);
  import itoa_pkg::*;

  logic [VALUE_W-1:0] raw;
  logic               raw_neg;
  logic [VALUE_W-1:0] raw_mag;

  assign raw     = in_ch.value;
  assign raw_neg = raw[VALUE_W-1];
  // two's complement negate; the most negative value maps onto 2^31 as unsigned
  assign raw_mag = raw_neg ? (~raw + VALUE_W'(1)) : raw;

  assign in_ch.ready = !job_valid || job_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      job_valid <= 1'b0;
    end else if (in_ch.ready) begin
      job_valid <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      job.negative <= raw_neg;
      job.mag      <= raw_mag;
    end
  end

endmodule
`default_nettype wire

[hw/rtl/itoa_queue.sv]
`default_nettype none
module itoa_queue (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            push_valid,
  input  wire itoa_pkg::job_t  push_job,
  output logic                 push_ready,
  output logic                 pop_valid,
  output itoa_pkg::job_t       pop_job,
  input  wire logic            pop_ready
);
  import itoa_pkg::*;

  job_t              entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;
  logic              do_push;
  logic              do_pop;

  assign push_ready = (count != QCNT_W'(QUEUE_DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_job    = entries[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + QPTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + QPTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + QCNT_W'(1);
      end else if (do_pop && !do_push) begin
        count <= count - QCNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_job;
    end
  end

endmodule
`default_nettype wire

[hw/rtl/itoa_back.sv]
`default_nettype none
module itoa_back (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            job_valid,
  input  wire itoa_pkg::job_t  job,
  output logic                 job_ready,
  itoa_out_if.source           out_ch
);
  import itoa_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_DIV  = 3'b010,
    S_EMIT = 3'b100
  } back_state_t;

  back_state_t            state;
  logic [VALUE_W-1:0]     mag;
  logic                   sign_pending;
  logic [DIGIT_W-1:0]     digits [MAX_DIGITS];
  logic [DIGIT_IDX_W-1:0] wr_idx;
  logic [DIGIT_IDX_W-1:0] rd_idx;

  logic                   out_valid;
  logic [CHAR_W-1:0]      out_char;
  logic                   out_last;

  logic [2*VALUE_W-1:0]   product;
  logic [QUOT_W-1:0]      quot;
  logic [DIGIT_W-1:0]     quot_x10_lo;
  logic [DIGIT_W-1:0]     digit;
  logic                   slot_free;
  logic                   emit_fire;

  // quotient by reciprocal multiply; the remainder needs only the low nibble
  assign product     = mag * RECIP_TEN;
  assign quot        = product[2*VALUE_W-1:RECIP_SHIFT];
  assign quot_x10_lo = {quot[0], 3'b000} + {quot[2:0], 1'b0};
  assign digit       = mag[DIGIT_W-1:0] - quot_x10_lo;

  assign job_ready = (state == S_IDLE);
  assign slot_free = !out_valid || out_ch.ready;
  assign emit_fire = (state == S_EMIT) && slot_free;

  assign out_ch.valid     = out_valid;
  assign out_ch.char_code = out_char;
  assign out_ch.last_char = out_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (job_valid) begin
            state <= S_DIV;
          end
        end
        S_DIV: begin
          if (quot == '0) begin
            state <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (emit_fire && !sign_pending && rd_idx == '0) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_IDLE && job_valid) begin
      mag          <= job.mag;
      sign_pending <= job.negative;
      wr_idx       <= '0;
    end
    if (state == S_DIV) begin
      digits[wr_idx] <= digit;
      mag            <= VALUE_W'(quot);
      wr_idx         <= wr_idx + DIGIT_IDX_W'(1);
      // most significant digit sits at the last slot written
      rd_idx         <= wr_idx;
    end
    if (emit_fire) begin
      if (sign_pending) begin
        sign_pending <= 1'b0;
      end else if (rd_idx != '0) begin
        rd_idx <= rd_idx - DIGIT_IDX_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (slot_free) begin
      out_valid <= emit_fire;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_fire) begin
      if (sign_pending) begin
        out_char <= CHAR_MINUS;
        out_last <= 1'b0;
      end else begin
        out_char <= CHAR_ZERO + CHAR_W'(digits[rd_idx]);
        out_last <= (rd_idx == '0);
      end
    end
  end

endmodule
`default_nettype wire

[hw/rtl/itoa_checker.sv]
`default_nettype none
module itoa_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic [5:0] char_code,
  input wire logic       last_char
);
  import itoa_pkg::*;

  // stalled word holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(char_code) && $stable(last_char))
    else $error("output word changed under stall");

  a_charset: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (char_code == CHAR_MINUS) ||
                  (char_code >= CHAR_ZERO && char_code <= CHAR_ZERO + CHAR_W'(9)))
    else $error("character outside minus and digits");

  a_minus_not_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && char_code == CHAR_MINUS |-> !last_char)
    else $error("minus sign flagged as last character");

  // after a minus the next word shown is a nonzero leading digit
  a_after_minus: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && char_code == CHAR_MINUS |=>
      !out_valid || (char_code > CHAR_ZERO && char_code <= CHAR_ZERO + CHAR_W'(9)))
    else $error("minus sign not followed by a nonzero leading digit");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output valid right after reset");

endmodule

bind signed_int_to_decimal_ascii_top itoa_checker u_itoa_checker (
  .clk       (clk),
  .rst       (rst),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .char_code (out_ch.char_code),
  .last_char (out_ch.last_char)
);
`default_nettype wire

[bench/signed_int_to_decimal_ascii_top_test.sv]
`default_nettype none
module signed_int_to_decimal_ascii_top_test;
  import itoa_pkg::*;

  localparam int unsigned STALL_LIMIT = 1000;
  localparam int unsigned TAIL_CYCLES = 40;

  typedef struct packed {
    logic [CHAR_W-1:0] code;
    logic              last;
  } text_char_t;

  logic clk;
  logic rst;

  itoa_in_if  in_ch();
  itoa_out_if out_ch();

  signed_int_to_decimal_ascii_top dut (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  text_char_t  expected_text[$];
  int          failures;
  int unsigned quiet_cycles;
  bit          src_idle;
  bit          sink_stall;

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  // mostly short gaps, now and then a long one
  function automatic int unsigned idle_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 30);
  endfunction

  // queue the characters of the decimal text of one number
  function automatic void predict_text(input logic signed [VALUE_W-1:0] v);
    logic [VALUE_W:0]  mag;
    logic [DIGIT_W-1:0] digits[MAX_DIGITS];
    int                ndig;
    text_char_t        c;
    // widen before negating so the most negative value keeps its magnitude
    mag = v[VALUE_W-1] ? ({(VALUE_W+1){1'b0}} - {v[VALUE_W-1], v}) : {1'b0, v};
    ndig = 0;
    do begin
      digits[ndig] = DIGIT_W'(mag % 10);
      mag = mag / 10;
      ndig++;
    end while (mag != 0 && ndig < MAX_DIGITS);
    if (v[VALUE_W-1]) begin
      c.code = CHAR_MINUS;
      c.last = 1'b0;
      expected_text.push_back(c);
    end
    for (int i = ndig - 1; i >= 0; i--) begin
      c.code = CHAR_ZERO + CHAR_W'(digits[i]);
      c.last = (i == 0);
      expected_text.push_back(c);
    end
  endfunction

  // half the time a uniform digit count, so short numbers show up often
  function automatic logic signed [VALUE_W-1:0] random_value();
    int unsigned     ndig;
    longint unsigned lo;
    longint unsigned hi;
    longint unsigned mag;
    bit              neg;
    if ($urandom_range(0, 1) == 0) return $urandom;
    ndig = $urandom_range(1, MAX_DIGITS);
    neg = $urandom_range(0, 1);
    lo = 1;
    repeat (ndig - 1) lo = lo * 10;
    hi = lo * 10 - 1;
    if (ndig == 1) lo = 0;
    if (hi > 64'd2147483647 + neg) hi = 64'd2147483647 + neg;
    mag = $urandom_range(32'(hi), 32'(lo));
    return neg ? VALUE_W'(64'd0 - mag) : VALUE_W'(mag);
  endfunction

  // called at a falling edge; returns at the falling edge after the word is taken
  task automatic send_value(input logic signed [VALUE_W-1:0] v);
    int unsigned gap;
    gap = src_idle ? idle_len() : 0;
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.value <= v;
    do @(posedge clk); while (!in_ch.ready);
    @(negedge clk);
  endtask

  initial begin
    int unsigned hold;
    hold = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold != 0) begin
        hold--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
        if (sink_stall && $urandom_range(0, 3) == 0) hold = idle_len();
      end
    end
  end

  always @(posedge clk) begin
    text_char_t want;
    if (!rst) begin
      if (in_ch.valid && in_ch.ready) predict_text(in_ch.value);
      if (out_ch.valid && out_ch.ready) begin
        if (expected_text.size() == 0) begin
          $error("unexpected word: char_code %0d last_char %0d",
                 out_ch.char_code, out_ch.last_char);
          failures++;
        end else begin
          want = expected_text.pop_front();
          if (out_ch.char_code !== want.code) begin
            $error("char_code: expected %0d, got %0d", want.code, out_ch.char_code);
            failures++;
          end
          if (out_ch.last_char !== want.last) begin
            $error("last_char: expected %0d, got %0d", want.last, out_ch.last_char);
            failures++;
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles + 1 >= STALL_LIMIT) begin
      $display("FAIL signed_int_to_decimal_ascii_top");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic test_edge_values();
    logic signed [VALUE_W-1:0] edge_vals[$];
    src_idle = 1'b0;
    sink_stall = 1'b0;
    edge_vals = '{0, 1, -1, 9, -9, 10, -10, 99, 100, -100, 12345, -12345,
                  999999999, -999999999, 1000000000, -1000000000, 1999999999,
                  2147483647, -2147483647, 32'sh8000_0000, 32'sh5555_5555,
                  32'shAAAA_AAAA};
    foreach (edge_vals[i]) send_value(edge_vals[i]);
  endtask

  task automatic test_streaming();
    src_idle = 1'b0;
    sink_stall = 1'b0;
    repeat (60) send_value(random_value());
  endtask

  task automatic test_sink_backpressure();
    src_idle = 1'b0;
    sink_stall = 1'b1;
    repeat (40) send_value(random_value());
  endtask

  task automatic test_random_idling();
    src_idle = 1'b1;
    sink_stall = 1'b1;
    repeat (340) send_value(random_value());
  endtask

  initial begin
    failures = 0;
    quiet_cycles = 0;
    src_idle = 1'b0;
    sink_stall = 1'b0;
    rst = 1'b1;
    in_ch.valid = 1'b0;
    in_ch.value = '0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    test_edge_values();
    test_streaming();
    test_sink_backpressure();
    test_random_idling();
    in_ch.valid <= 1'b0;

    while (expected_text.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (failures == 0) begin
      $display("PASS signed_int_to_decimal_ascii_top");
    end else begin
      $display("FAIL signed_int_to_decimal_ascii_top");
    end
    $finish;
  end

endmodule
`default_nettype wire
